FILE: rtl/core/sid_attribution_hash_table_macros.svh
// ----------------------------------------------------------------------------
// sid_attribution_hash_table_macros.svh
// Assertion helpers for the hash table RTL.
// ----------------------------------------------------------------------------
`ifndef SID_ATTRIBUTION_HASH_TABLE_MACROS_SVH
`define SID_ATTRIBUTION_HASH_TABLE_MACROS_SVH

// Clocked check, off while reset is asserted.
`define SIDHT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check, also active during reset.
`define SIDHT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

FILE: rtl/core/sidht_pkg.sv
// ----------------------------------------------------------------------------
// sidht_pkg
// Types and constants for the SID attribution hash table.
// ----------------------------------------------------------------------------
package sidht_pkg;

    localparam int CapacityDef = 1024;
    localparam int KeyW        = 32;
    localparam int SubW        = 16;
    localparam int LineW       = 24;
    localparam int SeqW        = 32;
    localparam int EntryCountW = 11;
    localparam int QueueDepth  = 2;

    // key mixing
    localparam logic [KeyW-1:0] HashMul1 = 32'h7feb352d;
    localparam logic [KeyW-1:0] HashMul2 = 32'h846ca68b;
    localparam int HashSh1 = 16;
    localparam int HashSh2 = 15;
    localparam int HashSh3 = 16;

    // load limit: new keys refused once load would exceed LoadNum / LoadDen
    localparam int LoadNum = 7;
    localparam int LoadDen = 10;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_REPLACED = 3'd1,
        ST_HIT      = 3'd2,
        ST_MISS     = 3'd3,
        ST_IGNORED  = 3'd4,
        ST_FULL     = 3'd5,
        ST_CLEARED  = 3'd6
    } t_status;

    // work class decided by the front end
    typedef enum logic [2:0] {
        CL_INSERT,
        CL_LOOKUP,
        CL_CLEAR,
        CL_MISS,
        CL_IGNORE
    } t_cls;

    typedef struct packed {
        t_cls              cls;
        logic [KeyW-1:0]   key_sid;
        logic [KeyW-1:0]   parent_rule;
        logic [SubW-1:0]   sub_idx;
        logic [LineW-1:0]  source_line;
        logic [KeyW-1:0]   hash;      // mix before the final xor-shift
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_qlink;

    typedef struct packed {
        logic [KeyW-1:0]  parent_rule;
        logic [SubW-1:0]  sub_idx;
        logic [SeqW-1:0]  seq_no;
        logic [LineW-1:0] source_line;
    } t_rec;

endpackage

FILE: rtl/core/sid_attribution_hash_table.sv
// ----------------------------------------------------------------------------
// sid_attribution_hash_table
// Record table keyed by nonzero 32-bit SID, open addressing with linear probe.
// ----------------------------------------------------------------------------
// Operation: after reset the key memory is swept to empty, slot by slot,
// during which o_in_stall stays high. The front end computes the key mix
// with two registered 32x32 multiplies (S_MUL1, S_MUL2) and takes a new
// command only when idle or, once the last job is in S_PUSH, when the queue
// has room; it hands each job through a 2-entry queue to the table engine.
// The engine starts a job in S_IDLE and then reads the key and record memory
// one slot after another in S_PROBE, with new keys refused at the 0.7 load
// cap; a miss while disabled or an ignored command is answered from S_IDLE,
// and a clear sweeps the key memory in S_SWEEP. Each command gives exactly
// one result, held in an output register until it is transferred.
// ----------------------------------------------------------------------------
module sid_attribution_hash_table #(
    parameter int CAPACITY = sidht_pkg::CapacityDef
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_command,
    input  logic [sidht_pkg::KeyW-1:0]         i_key_sid,
    input  logic [sidht_pkg::KeyW-1:0]         i_parent_rule,
    input  logic [sidht_pkg::SubW-1:0]         i_sub_idx,
    input  logic [sidht_pkg::LineW-1:0]        i_source_line,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [2:0]                         o_status,
    output logic [sidht_pkg::KeyW-1:0]         o_found_parent_rule,
    output logic [sidht_pkg::SubW-1:0]         o_found_sub_idx,
    output logic                               o_found_is_hook,
    output logic [sidht_pkg::SeqW-1:0]         o_found_seq_no,
    output logic [sidht_pkg::LineW-1:0]        o_found_source_line,
    output logic [sidht_pkg::EntryCountW-1:0]  o_entry_count
);
    import sidht_pkg::*;

    logic   r_enabled;
    logic   init_busy;
    logic   q_full;
    logic   q_pop;
    t_qlink push;
    t_qlink head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
        end else if (i_cfg_we) begin
            r_enabled <= i_cfg_wdata;
        end
    end

    sidht_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_hold        (init_busy),
        .i_enabled     (r_enabled),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_key_sid     (i_key_sid),
        .i_parent_rule (i_parent_rule),
        .i_sub_idx     (i_sub_idx),
        .i_source_line (i_source_line),
        .i_q_full      (q_full),
        .o_push        (push)
    );

    sidht_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_head  (head),
        .i_pop   (q_pop)
    );

    sidht_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_head              (head),
        .o_pop               (q_pop),
        .o_init_busy         (init_busy),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_status            (o_status),
        .o_found_parent_rule (o_found_parent_rule),
        .o_found_sub_idx     (o_found_sub_idx),
        .o_found_is_hook     (o_found_is_hook),
        .o_found_seq_no      (o_found_seq_no),
        .o_found_source_line (o_found_source_line),
        .o_entry_count       (o_entry_count)
    );

endmodule

FILE: rtl/core/sidht_front.sv
// ----------------------------------------------------------------------------
// sidht_front
// Accepts commands, classifies them and computes the key mix.
// ----------------------------------------------------------------------------
module sidht_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_hold,
    input  logic                           i_enabled,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_command,
    input  logic [sidht_pkg::KeyW-1:0]     i_key_sid,
    input  logic [sidht_pkg::KeyW-1:0]     i_parent_rule,
    input  logic [sidht_pkg::SubW-1:0]     i_sub_idx,
    input  logic [sidht_pkg::LineW-1:0]    i_source_line,
    input  logic                           i_q_full,
    output sidht_pkg::t_qlink              o_push
);
    import sidht_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_PUSH
    } t_fstate;

    t_fstate         r_state, n_state;
    t_job            r_job, n_job;
    t_cls            cls;
    logic            key_ok;
    logic            can_take;
    logic            accept;
    logic [KeyW-1:0] mix2;

    always_comb begin
        key_ok = i_enabled && (i_key_sid != '0);
        unique case (t_cmd'(i_command))
            CMD_INSERT: cls = key_ok ? CL_INSERT : CL_IGNORE;
            CMD_LOOKUP: cls = key_ok ? CL_LOOKUP : CL_MISS;
            CMD_CLEAR:  cls = CL_CLEAR;
            default:    cls = CL_IGNORE;
        endcase
    end

    assign can_take   = !i_hold && ((r_state == S_IDLE) || ((r_state == S_PUSH) && !i_q_full));
    assign accept     = i_in_valid && can_take;
    assign o_in_stall = !can_take;
    assign mix2       = r_job.hash ^ (r_job.hash >> HashSh2);

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                n_state    = S_MUL2;
                n_job.hash = r_job.hash * HashMul1;
            end
            S_MUL2: begin
                n_state    = S_PUSH;
                n_job.hash = mix2 * HashMul2;
            end
            S_PUSH: begin
                if (!i_q_full) begin
                    n_state = accept ? S_MUL1 : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (accept) begin
            n_job.cls         = cls;
            n_job.key_sid     = i_key_sid;
            n_job.parent_rule = i_parent_rule;
            n_job.sub_idx     = i_sub_idx;
            n_job.source_line = i_source_line;
            n_job.hash        = i_key_sid ^ (i_key_sid >> HashSh1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_job <= n_job;
    end

    assign o_push.valid = (r_state == S_PUSH);
    assign o_push.job   = r_job;

endmodule

FILE: rtl/core/sidht_queue.sv
// ----------------------------------------------------------------------------
// sidht_queue
// Short FIFO of classified jobs between the front end and the table engine.
// ----------------------------------------------------------------------------
module sidht_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sidht_pkg::t_qlink  i_push,
    output logic               o_full,
    output sidht_pkg::t_qlink  o_head,
    input  logic               i_pop
);
    import sidht_pkg::*;

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);

    t_job            r_mem [QueueDepth];
    logic [PtrW-1:0] r_wp, r_rp;
    logic [CntW-1:0] r_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == CntW'(QueueDepth));
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PtrW'(QueueDepth - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PtrW'(QueueDepth - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
        if (do_push) begin
            r_mem[r_wp] <= i_push.job;
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.job   = r_mem[r_rp];

endmodule

FILE: rtl/core/sidht_back.sv
// ----------------------------------------------------------------------------
// sidht_back
// Table engine: key and record memories, linear probe, clear sweep,
// result register.
// ----------------------------------------------------------------------------
`include "sid_attribution_hash_table_macros.svh"

module sidht_back #(
    parameter int CAPACITY = sidht_pkg::CapacityDef
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sidht_pkg::t_qlink                  i_head,
    output logic                               o_pop,
    output logic                               o_init_busy,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [2:0]                         o_status,
    output logic [sidht_pkg::KeyW-1:0]         o_found_parent_rule,
    output logic [sidht_pkg::SubW-1:0]         o_found_sub_idx,
    output logic                               o_found_is_hook,
    output logic [sidht_pkg::SeqW-1:0]         o_found_seq_no,
    output logic [sidht_pkg::LineW-1:0]        o_found_source_line,
    output logic [sidht_pkg::EntryCountW-1:0]  o_entry_count
);
    import sidht_pkg::*;

    localparam int SlotW     = $clog2(CAPACITY);
    localparam int CntW      = SlotW + 1;
    localparam int LoadLimit = (CAPACITY * LoadNum) / LoadDen;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_PROBE,
        S_SWEEP
    } t_bstate;

    logic [KeyW-1:0] key_mem [CAPACITY];
    t_rec            rec_mem [CAPACITY];

    t_bstate          r_state, n_state;
    t_job             r_job, n_job;
    logic [SlotW-1:0] r_idx, n_idx;
    logic [SlotW-1:0] r_n, n_n;
    logic [CntW-1:0]  r_count, n_count;
    logic [SeqW-1:0]  r_seq, n_seq;
    logic [KeyW-1:0]  r_key_rd;
    t_rec             r_rec_rd;

    logic             r_out_valid, n_out_valid;
    t_status          r_status, n_status;
    logic [KeyW-1:0]  r_fparent, n_fparent;
    logic [SubW-1:0]  r_fsub, n_fsub;
    logic             r_fhook, n_fhook;
    logic [SeqW-1:0]  r_fseq, n_fseq;
    logic [LineW-1:0] r_fline, n_fline;
    logic [CntW-1:0]  r_fcount, n_fcount;

    logic [KeyW-1:0]  home_mix;
    logic [SlotW-1:0] home;
    logic [SlotW-1:0] rd_addr;
    logic             key_we, rec_we;
    logic [KeyW-1:0]  key_wd;
    t_rec             rec_wd;
    logic             out_free, out_load;
    logic             k_empty, k_match, probe_last, sweep_last, load_full;

    assign home_mix   = i_head.job.hash ^ (i_head.job.hash >> HashSh3);
    assign home       = home_mix[SlotW-1:0];
    assign out_free   = !r_out_valid || !i_out_stall;
    assign k_empty    = (r_key_rd == '0);
    assign k_match    = (r_key_rd == r_job.key_sid);
    assign probe_last = (r_n == {SlotW{1'b1}});
    assign sweep_last = (r_idx == {SlotW{1'b1}});
    assign load_full  = (r_count >= CntW'(LoadLimit));

    assign rec_wd.parent_rule = r_job.parent_rule;
    assign rec_wd.sub_idx     = r_job.sub_idx;
    assign rec_wd.seq_no      = r_seq;
    assign rec_wd.source_line = r_job.source_line;

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_idx       = r_idx;
        n_n         = r_n;
        n_count     = r_count;
        n_seq       = r_seq;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_fparent   = r_fparent;
        n_fsub      = r_fsub;
        n_fhook     = r_fhook;
        n_fseq      = r_fseq;
        n_fline     = r_fline;
        n_fcount    = r_fcount;
        out_load    = 1'b0;
        o_pop       = 1'b0;
        key_we      = 1'b0;
        key_wd      = '0;
        rec_we      = 1'b0;
        rd_addr     = r_idx + 1'b1;

        unique case (r_state)
            S_INIT: begin
                key_we = 1'b1;
                n_idx  = r_idx + 1'b1;
                if (sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                rd_addr = home;
                if (i_head.valid && out_free) begin
                    o_pop = 1'b1;
                    n_job = i_head.job;
                    n_idx = home;
                    n_n   = '0;
                    case (i_head.job.cls) inside
                        CL_INSERT, CL_LOOKUP: n_state = S_PROBE;
                        CL_CLEAR: begin
                            n_state = S_SWEEP;
                            n_idx   = '0;
                        end
                        CL_MISS: begin
                            out_load = 1'b1;
                            n_status = ST_MISS;
                        end
                        default: begin
                            out_load = 1'b1;
                            n_status = ST_IGNORED;
                        end
                    endcase
                end
            end
            S_PROBE: begin
                if (r_job.cls == CL_INSERT) begin
                    if (k_match) begin
                        rec_we   = 1'b1;
                        out_load = 1'b1;
                        n_status = ST_REPLACED;
                        n_fseq   = r_seq;
                        n_seq    = r_seq + 1'b1;
                    end else if (k_empty && !load_full) begin
                        key_we   = 1'b1;
                        key_wd   = r_job.key_sid;
                        rec_we   = 1'b1;
                        out_load = 1'b1;
                        n_status = ST_INSERTED;
                        n_fseq   = r_seq;
                        n_seq    = r_seq + 1'b1;
                        n_count  = r_count + 1'b1;
                    end else if (k_empty || probe_last) begin
                        out_load = 1'b1;
                        n_status = ST_FULL;
                    end
                end else begin
                    if (k_match && !k_empty) begin
                        out_load  = 1'b1;
                        n_status  = ST_HIT;
                        n_fparent = r_rec_rd.parent_rule;
                        n_fsub    = r_rec_rd.sub_idx;
                        n_fhook   = (r_rec_rd.sub_idx == '0);
                        n_fseq    = r_rec_rd.seq_no;
                        n_fline   = r_rec_rd.source_line;
                    end else if (k_empty || probe_last) begin
                        out_load = 1'b1;
                        n_status = ST_MISS;
                    end
                end
                if (out_load) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_n   = r_n + 1'b1;
                end
            end
            S_SWEEP: begin
                key_we = 1'b1;
                n_idx  = r_idx + 1'b1;
                if (sweep_last) begin
                    n_state  = S_IDLE;
                    n_count  = '0;
                    n_seq    = SeqW'(1);
                    out_load = 1'b1;
                    n_status = ST_CLEARED;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
            n_fcount    = n_count;
            if (n_status != ST_HIT) begin
                n_fparent = '0;
                n_fsub    = '0;
                n_fhook   = 1'b0;
                n_fline   = '0;
                if ((n_status != ST_INSERTED) && (n_status != ST_REPLACED)) begin
                    n_fseq = '0;
                end
            end
        end
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_idx       <= '0;
            r_n         <= '0;
            r_count     <= '0;
            r_seq       <= SeqW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_n         <= n_n;
            r_count     <= n_count;
            r_seq       <= n_seq;
            r_out_valid <= n_out_valid;
        end
        r_job     <= n_job;
        r_status  <= n_status;
        r_fparent <= n_fparent;
        r_fsub    <= n_fsub;
        r_fhook   <= n_fhook;
        r_fseq    <= n_fseq;
        r_fline   <= n_fline;
        r_fcount  <= n_fcount;
    end

    // key and record memories, registered read
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[r_idx] <= key_wd;
        end
        r_key_rd <= key_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (rec_we) begin
            rec_mem[r_idx] <= rec_wd;
        end
        r_rec_rd <= rec_mem[rd_addr];
    end

    assign o_init_busy         = (r_state == S_INIT);
    assign o_out_valid         = r_out_valid;
    assign o_status            = r_status;
    assign o_found_parent_rule = r_fparent;
    assign o_found_sub_idx     = r_fsub;
    assign o_found_is_hook     = r_fhook;
    assign o_found_seq_no      = r_fseq;
    assign o_found_source_line = r_fline;
    assign o_entry_count       = EntryCountW'(r_fcount);

    `SIDHT_ASSERT(a_count_limit, i_clk, i_rst_n, r_count <= CntW'(LoadLimit), "count over load limit")
    `SIDHT_ASSERT(a_insert_counts, i_clk, i_rst_n, (r_state == S_PROBE && key_we) |=> (r_count == $past(r_count) + 1'b1), "new key not counted")
    `SIDHT_ASSERT(a_clear_resets, i_clk, i_rst_n, (r_state == S_SWEEP && sweep_last) |=> (r_count == '0 && r_seq == SeqW'(1)), "clear left count or sequence")
    `SIDHT_ASSERT(a_hit_hook, i_clk, i_rst_n, (r_out_valid && r_status == ST_HIT) |-> (r_fhook == (r_fsub == '0)), "hook flag disagrees with sub-index")

endmodule

FILE: tb/tb_sid_attribution_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sid_attribution_hash_table
// Self-checking bench for the SID record table. A short table of directed
// operations is followed by random traffic: the table is filled up to its
// load cap, keys are steered onto shared and wrapping probe chains, clears
// come within random runs and enable changes between them. Every result is
// checked against a fixed directed reply or a behavioral copy of the table.
// ----------------------------------------------------------------------------
module tb_sid_attribution_hash_table;
    import sidht_pkg::*;

    localparam int CAP       = 1024;
    localparam int SLOT_W    = $clog2(CAP);
    localparam int RUN_LIMIT = 10_000_000;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        t_status            status;
        logic [KeyW-1:0]    parent;
        logic [SubW-1:0]    sub;
        logic               hook;
        logic [SeqW-1:0]    seq_no;
        logic [LineW-1:0]   line;
        logic [EntryCountW-1:0] count;
    } t_table_reply;

    typedef struct packed {
        logic              is_cfg;
        logic              en;
        logic [1:0]        cmd;
        logic [KeyW-1:0]   key;
        logic [KeyW-1:0]   parent;
        logic [SubW-1:0]   sub;
        logic [LineW-1:0]  line;
        logic              typed;
        t_table_reply      reply;
    } t_dir_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic                    i_cfg_wdata = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic [1:0]              i_command = '0;
    logic [KeyW-1:0]         i_key_sid = '0;
    logic [KeyW-1:0]         i_parent_rule = '0;
    logic [SubW-1:0]         i_sub_idx = '0;
    logic [LineW-1:0]        i_source_line = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [2:0]              o_status;
    logic [KeyW-1:0]         o_found_parent_rule;
    logic [SubW-1:0]         o_found_sub_idx;
    logic                    o_found_is_hook;
    logic [SeqW-1:0]         o_found_seq_no;
    logic [LineW-1:0]        o_found_source_line;
    logic [EntryCountW-1:0]  o_entry_count;

    // bench copy of the table
    logic [KeyW-1:0]         tbl_key [CAP];
    t_rec                    tbl_rec [CAP];
    logic [EntryCountW-1:0]  tbl_count;
    logic [SeqW-1:0]         tbl_next_seq;
    logic                    tbl_enabled;

    t_table_reply  reply_q [$];
    logic [KeyW-1:0] key_pool [$];
    t_dir_row      dir_tab [$];

    int send_idle_pct = 16;
    int recv_idle_pct = 59;
    int err_count = 0;
    int xfer_count = 0;
    int status_seen [8];
    int cycle_cnt = 0;

    sid_attribution_hash_table #(
        .CAPACITY(CAP)
    ) u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_command           (i_command),
        .i_key_sid           (i_key_sid),
        .i_parent_rule       (i_parent_rule),
        .i_sub_idx           (i_sub_idx),
        .i_source_line       (i_source_line),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_status            (o_status),
        .o_found_parent_rule (o_found_parent_rule),
        .o_found_sub_idx     (o_found_sub_idx),
        .o_found_is_hook     (o_found_is_hook),
        .o_found_seq_no      (o_found_seq_no),
        .o_found_source_line (o_found_source_line),
        .o_entry_count       (o_entry_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, reply_q.size());
            $display("tb_sid_attribution_hash_table: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // behavioral table
    // ------------------------------------------------------------------
    function automatic logic [SLOT_W-1:0] key_home(input logic [KeyW-1:0] k);
        logic [KeyW-1:0] h;
        h = k;
        h = h ^ (h >> HashSh1);
        h = h * HashMul1;
        h = h ^ (h >> HashSh2);
        h = h * HashMul2;
        h = h ^ (h >> HashSh3);
        return h[SLOT_W-1:0];
    endfunction

    // 1: key found, 0: empty slot ends the chain, -1: neither
    function automatic int table_probe(input logic [KeyW-1:0] k,
                                       output logic [SLOT_W-1:0] slot);
        logic [SLOT_W-1:0] idx;
        idx = key_home(k);
        slot = idx;
        for (int n = 0; n < CAP; n++) begin
            if (tbl_key[idx] == '0) begin
                slot = idx;
                return 0;
            end
            if (tbl_key[idx] == k) begin
                slot = idx;
                return 1;
            end
            idx = idx + 1'b1;
        end
        return -1;
    endfunction

    function automatic t_table_reply table_apply(input logic [1:0] cmd,
                                                 input logic [KeyW-1:0] key,
                                                 input logic [KeyW-1:0] par,
                                                 input logic [SubW-1:0] sub,
                                                 input logic [LineW-1:0] ln);
        t_table_reply r;
        logic [SLOT_W-1:0] slot;
        int found;
        r = '0;
        r.status = ST_IGNORED;
        case (cmd)
            CMD_INSERT: begin
                if (tbl_enabled && key != '0) begin
                    found = table_probe(key, slot);
                    // only a new key counts against the load cap
                    if (found != 1 && (int'(tbl_count) + 1) * LoadDen > CAP * LoadNum)
                        found = -1;
                    if (found < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        if (found == 1) begin
                            r.status = ST_REPLACED;
                        end else begin
                            r.status = ST_INSERTED;
                            tbl_key[slot] = key;
                            tbl_count = tbl_count + 1'b1;
                        end
                        tbl_rec[slot] = '{parent_rule: par, sub_idx: sub,
                                          seq_no: tbl_next_seq, source_line: ln};
                        r.seq_no = tbl_next_seq;
                        tbl_next_seq = tbl_next_seq + 1'b1;
                    end
                end
            end
            CMD_LOOKUP: begin
                r.status = ST_MISS;
                if (tbl_enabled && key != '0 && table_probe(key, slot) == 1) begin
                    r.status = ST_HIT;
                    r.parent = tbl_rec[slot].parent_rule;
                    r.sub    = tbl_rec[slot].sub_idx;
                    r.hook   = (tbl_rec[slot].sub_idx == '0);
                    r.seq_no = tbl_rec[slot].seq_no;
                    r.line   = tbl_rec[slot].source_line;
                end
            end
            CMD_CLEAR: begin
                foreach (tbl_key[i]) tbl_key[i] = '0;
                tbl_count = '0;
                tbl_next_seq = 1;
                r.status = ST_CLEARED;
            end
            default: ;
        endcase
        r.count = tbl_count;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_table_reply got;
        t_table_reply want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got = '{status: t_status'(o_status), parent: o_found_parent_rule,
                        sub: o_found_sub_idx, hook: o_found_is_hook,
                        seq_no: o_found_seq_no, line: o_found_source_line,
                        count: o_entry_count};
                xfer_count++;
                status_seen[o_status]++;
                if (reply_q.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("result transfer with none outstanding: status %0d",
                                 o_status);
                end else begin
                    want = reply_q.pop_front();
                    if (got !== want) begin
                        err_count++;
                        if (err_count <= 10) begin
                            $display("mismatch at transfer %0d", xfer_count);
                            $display("  exp st %0d par %h sub %h hook %b seq %h line %h cnt %0d",
                                     want.status, want.parent, want.sub, want.hook,
                                     want.seq_no, want.line, want.count);
                            $display("  got st %0d par %h sub %h hook %b seq %h line %h cnt %0d",
                                     got.status, got.parent, got.sub, got.hook,
                                     got.seq_no, got.line, got.count);
                        end
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic push_item(input logic [1:0] cmd, input logic [KeyW-1:0] key,
                             input logic [KeyW-1:0] par, input logic [SubW-1:0] sub,
                             input logic [LineW-1:0] ln, input logic typed,
                             input t_table_reply fixed);
        int gap;
        t_table_reply pred;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_key_sid     <= key;
        i_parent_rule <= par;
        i_sub_idx     <= sub;
        i_source_line <= ln;
        pred = table_apply(cmd, key, par, sub, ln);
        reply_q.push_back(typed ? fixed : pred);
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // hold off input until every outstanding result has been transferred
    task automatic drain_table();
        i_in_valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_enable(input logic en);
        drain_table();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= en;
        tbl_enabled = en;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [KeyW-1:0] pooled_key(input logic [KeyW-1:0] fallback);
        if (key_pool.size() == 0)
            return fallback;
        return key_pool[$urandom_range(key_pool.size() - 1)];
    endfunction

    // random key whose home slot is the target, to build probe chains
    function automatic logic [KeyW-1:0] key_at_slot(input logic [SLOT_W-1:0] target);
        logic [KeyW-1:0] k;
        k = $urandom;
        for (int n = 0; n < 16384 && key_home(k) != target; n++)
            k = $urandom;
        return k;
    endfunction

    task automatic run_random(input int n, input logic fill);
        int r;
        logic [1:0] cmd;
        logic [KeyW-1:0] key;
        logic [SubW-1:0] sub;
        logic [SLOT_W-1:0] target;
        for (int i = 0; i < n; i++) begin
            r   = $urandom_range(999);
            cmd = CMD_LOOKUP;
            key = $urandom;
            if (r < (fill ? 700 : 350)) begin
                cmd = CMD_INSERT;
                if ($urandom_range(9) == 0) begin
                    // share a chain with a live key, or start at the last slot to wrap
                    target = (key_pool.size() != 0 && $urandom_range(1) == 1)
                           ? key_home(pooled_key(key)) : SLOT_W'(CAP - 1);
                    key = key_at_slot(target);
                end
                key_pool.push_back(key);
            end else if (r < (fill ? 800 : 500)) begin
                cmd = CMD_INSERT;
                key = pooled_key(key);
            end else if (r < (fill ? 920 : 800)) begin
                key = pooled_key(key);
            end else if (r < 960) begin
                // lookup of an unrelated key
            end else if (r < 980) begin
                cmd = ($urandom_range(1) == 1) ? CMD_INSERT : CMD_LOOKUP;
                key = '0;
            end else if (r < (fill ? 1000 : 985)) begin
                cmd = CMD_UNUSED;
            end else begin
                cmd = CMD_CLEAR;
                key_pool.delete();
            end
            sub = ($urandom_range(3) == 0) ? '0 : SubW'($urandom);
            push_item(cmd, key, $urandom, sub, LineW'($urandom), 1'b0, '0);
            if (key_pool.size() > 1500)
                key_pool.delete(0);
            if (i == n / 2)
                drain_table();
        end
    endtask

    function automatic t_table_reply rep(input t_status st, input logic [KeyW-1:0] par,
                                         input logic [SubW-1:0] sub, input logic hk,
                                         input logic [SeqW-1:0] sq,
                                         input logic [LineW-1:0] ln,
                                         input logic [EntryCountW-1:0] cnt);
        return '{status: st, parent: par, sub: sub, hook: hk, seq_no: sq,
                 line: ln, count: cnt};
    endfunction

    function automatic t_dir_row op(input logic [1:0] cmd, input logic [KeyW-1:0] key,
                                    input logic [KeyW-1:0] par, input logic [SubW-1:0] sub,
                                    input logic [LineW-1:0] ln, input logic typed,
                                    input t_table_reply rp);
        return '{is_cfg: 1'b0, en: 1'b0, cmd: cmd, key: key, parent: par, sub: sub,
                 line: ln, typed: typed, reply: rp};
    endfunction

    function automatic t_dir_row cfg_row(input logic en);
        t_dir_row d;
        d = '0;
        d.is_cfg = 1'b1;
        d.en = en;
        return d;
    endfunction

    initial begin
        foreach (tbl_key[i]) tbl_key[i] = '0;
        foreach (status_seen[i]) status_seen[i] = 0;
        tbl_count    = '0;
        tbl_next_seq = 1;
        tbl_enabled  = 1'b0;

        // disabled after reset
        dir_tab.push_back(op(CMD_INSERT, 32'd5, 32'hA5A5_A5A5, 16'd1, 24'd10, 1'b1,
                             rep(ST_IGNORED, '0, '0, 1'b0, '0, '0, 11'd0)));
        dir_tab.push_back(op(CMD_LOOKUP, 32'd5, '0, '0, '0, 1'b1,
                             rep(ST_MISS, '0, '0, 1'b0, '0, '0, 11'd0)));
        dir_tab.push_back(op(CMD_UNUSED, 32'd5, '0, '0, '0, 1'b1,
                             rep(ST_IGNORED, '0, '0, 1'b0, '0, '0, 11'd0)));
        dir_tab.push_back(op(CMD_CLEAR, '0, '0, '0, '0, 1'b1,
                             rep(ST_CLEARED, '0, '0, 1'b0, '0, '0, 11'd0)));
        dir_tab.push_back(cfg_row(1'b1));
        // reserved key
        dir_tab.push_back(op(CMD_INSERT, '0, 32'h1, 16'h1, 24'h1, 1'b1,
                             rep(ST_IGNORED, '0, '0, 1'b0, '0, '0, 11'd0)));
        dir_tab.push_back(op(CMD_LOOKUP, '0, '0, '0, '0, 1'b1,
                             rep(ST_MISS, '0, '0, 1'b0, '0, '0, 11'd0)));
        // all-ones and all-zero records
        dir_tab.push_back(op(CMD_INSERT, '1, '1, '1, '1, 1'b1,
                             rep(ST_INSERTED, '0, '0, 1'b0, 32'd1, '0, 11'd1)));
        dir_tab.push_back(op(CMD_LOOKUP, '1, '0, '0, '0, 1'b1,
                             rep(ST_HIT, '1, '1, 1'b0, 32'd1, '1, 11'd1)));
        dir_tab.push_back(op(CMD_INSERT, 32'd1, '0, '0, '0, 1'b1,
                             rep(ST_INSERTED, '0, '0, 1'b0, 32'd2, '0, 11'd2)));
        dir_tab.push_back(op(CMD_LOOKUP, 32'd1, '0, '0, '0, 1'b1,
                             rep(ST_HIT, '0, '0, 1'b1, 32'd2, '0, 11'd2)));
        dir_tab.push_back(op(CMD_INSERT, '1, 32'h1234_5678, 16'd7, 24'd99, 1'b1,
                             rep(ST_REPLACED, '0, '0, 1'b0, 32'd3, '0, 11'd2)));
        dir_tab.push_back(op(CMD_LOOKUP, '1, '0, '0, '0, 1'b0, '0));
        dir_tab.push_back(op(CMD_LOOKUP, 32'd2, '0, '0, '0, 1'b1,
                             rep(ST_MISS, '0, '0, 1'b0, '0, '0, 11'd2)));
        dir_tab.push_back(op(CMD_UNUSED, 32'd1, '1, '1, '1, 1'b1,
                             rep(ST_IGNORED, '0, '0, 1'b0, '0, '0, 11'd2)));
        dir_tab.push_back(op(CMD_INSERT, '0, '1, '1, '1, 1'b1,
                             rep(ST_IGNORED, '0, '0, 1'b0, '0, '0, 11'd2)));
        dir_tab.push_back(op(CMD_LOOKUP, 32'h8000_0000, '0, '0, '0, 1'b0, '0));
        // clear restarts the sequence
        dir_tab.push_back(op(CMD_CLEAR, '1, '1, '1, '1, 1'b1,
                             rep(ST_CLEARED, '0, '0, 1'b0, '0, '0, 11'd0)));
        dir_tab.push_back(op(CMD_LOOKUP, 32'd1, '0, '0, '0, 1'b1,
                             rep(ST_MISS, '0, '0, 1'b0, '0, '0, 11'd0)));
        dir_tab.push_back(op(CMD_INSERT, 32'd1, 32'hDEAD, '0, '1, 1'b1,
                             rep(ST_INSERTED, '0, '0, 1'b0, 32'd1, '0, 11'd1)));
        // disabled with a live entry; clear still works
        dir_tab.push_back(cfg_row(1'b0));
        dir_tab.push_back(op(CMD_LOOKUP, 32'd1, '0, '0, '0, 1'b1,
                             rep(ST_MISS, '0, '0, 1'b0, '0, '0, 11'd1)));
        dir_tab.push_back(op(CMD_INSERT, 32'd3, '1, '0, '1, 1'b1,
                             rep(ST_IGNORED, '0, '0, 1'b0, '0, '0, 11'd1)));
        dir_tab.push_back(op(CMD_CLEAR, '0, '0, '0, '0, 1'b1,
                             rep(ST_CLEARED, '0, '0, 1'b0, '0, '0, 11'd0)));
        dir_tab.push_back(cfg_row(1'b1));
        dir_tab.push_back(op(CMD_INSERT, 32'd1, 32'h55AA_55AA, 16'h8000, 24'h80_0000, 1'b1,
                             rep(ST_INSERTED, '0, '0, 1'b0, 32'd1, '0, 11'd1)));
        dir_tab.push_back(op(CMD_LOOKUP, 32'd1, '0, '0, '0, 1'b0, '0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_cfg)
                write_enable(dir_tab[i].en);
            else
                push_item(dir_tab[i].cmd, dir_tab[i].key, dir_tab[i].parent,
                          dir_tab[i].sub, dir_tab[i].line, dir_tab[i].typed,
                          dir_tab[i].reply);
        end

        // fill toward the load cap
        run_random(700, 1'b1);
        write_enable(1'b1);
        send_idle_pct = 59;
        recv_idle_pct = 16;
        run_random(500, 1'b1);

        // no idling from here on
        write_enable(1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(30, 1'b0);
        write_enable(1'b1);
        run_random(400, 1'b0);

        i_in_valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("%0d results: %0d inserted, %0d replaced, %0d hit, %0d miss, %0d ignored,",
                 xfer_count, status_seen[ST_INSERTED], status_seen[ST_REPLACED],
                 status_seen[ST_HIT], status_seen[ST_MISS], status_seen[ST_IGNORED]);
        $display("  %0d refused at load cap, %0d clears; %0d mismatches in %0d cycles",
                 status_seen[ST_FULL], status_seen[ST_CLEARED], err_count, cycle_cnt);
        if (err_count == 0)
            $display("tb_sid_attribution_hash_table: clean");
        else
            $display("tb_sid_attribution_hash_table: errors");
        $finish;
    end

endmodule
